// ----- src/bbs_pkg.sv -----
// Shared types and constants for the biphasic burst stimulator.
// No dependencies; imported by every module of the block.
package bbs_pkg;

    // Strength ceiling for the plus/minus buttons
    localparam logic [3:0]  MAX_LEVEL = 4'd9;

    localparam logic [12:0] DUTY_MAX  = 13'h1FFF;
    localparam logic [15:0] T16_MAX   = 16'hFFFF;

    // Register reset values
    localparam logic [7:0]  PHASE_TICKS_RST   = 8'd10;
    localparam logic [7:0]  PULSES_RST        = 8'd20;
    localparam logic [15:0] REST_TICKS_RST    = 16'd2000;
    localparam logic [15:0] DEBOUNCE_RST      = 16'd500;
    localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [12:0] DUTY_STEP_RST     = 13'd819;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_PHASE_TICKS = 3'd0;
    localparam logic [2:0] REG_PULSES      = 3'd1;
    localparam logic [2:0] REG_REST_TICKS  = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd4;
    localparam logic [2:0] REG_DUTY_STEP   = 3'd5;

    // Button bit positions in the input item
    localparam int KEY_UP    = 0;
    localparam int KEY_DOWN  = 1;
    localparam int KEY_POWER = 2;

    typedef enum logic [1:0] {
        PH_FWD  = 2'd0,
        PH_REV  = 2'd1,
        PH_OFF  = 2'd2,
        PH_REST = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]  phase_ticks;
        logic [7:0]  pulses_per_burst;
        logic [15:0] rest_ticks;
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [12:0] duty_step;
    } t_cfg;

    // Button handling results for one tick
    typedef struct packed {
        logic [3:0] strength;
        logic       short_press;
        logic       sleep_request;
    } t_btn_res;

    // Stimulator results for one tick
    typedef struct packed {
        logic        drive_forward;
        logic        drive_reverse;
        logic [12:0] pwm_duty;
        logic        burst_start;
    } t_stim_res;

endpackage

// ----- src/biphasic_burst_stimulator_top.sv -----
// Top level of the biphasic burst stimulator: stream ports, APB registers.
// Depends on bbs_pkg, bbs_regs, bbs_buttons and bbs_stim.
//
// Usage:
//   Each input transaction on the s-side is one 1 ms tick carrying the
//   sampled active-low buttons. Every tick produces exactly one output
//   transaction on the m-side with the bridge drive, PWM duty, strength
//   level and the burst-start, short-press and sleep-request flags.
//   An accepted item lands in the input register; its result is computed
//   and written to the output register once that register is free or is
//   being read, and shown from then on. Throughput: one tick per cycle
//   unless the receiver stalls, set by the single pass from input register
//   through the button and sequencer logic to the output register.
//   When the receiver stalls, the result holds in the output register and
//   one more tick waits in the input register; o_s_tready then drops.
//   Reset (i_rst_n low, synchronous) empties both registers, restores the
//   default register values and restarts at the first tick of a burst.
//   Users must write registers over APB only while no tick is in flight; it is unguarded.
module biphasic_burst_stimulator_top #(
    parameter logic [3:0] MAX_LEVEL = bbs_pkg::MAX_LEVEL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input tick stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] plus_button, [1] minus_button, [2] power_button
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] drive_forward, [1] drive_reverse, [14:2] pwm_duty,
                                     // [18:15] strength_level, [19] burst_start,
                                     // [20] short_press, [21] sleep_request
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bbs_pkg::*;

    t_cfg        cfg;
    t_btn_res    btn_res;
    t_stim_res   stim_res;
    logic        r_in_valid;
    logic [2:0]  r_in_btn;
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        adv;

    // Process the held tick when the output register is free
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    // Hold the accepted transaction in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_btn <= i_s_tdata[2:0];
        end
    end

    bbs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbs_buttons #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_buttons (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_btn   (r_in_btn),
        .i_cfg   (cfg),
        .o_res   (btn_res)
    );

    bbs_stim u_stim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_strength (btn_res.strength),
        .i_cfg      (cfg),
        .o_res      (stim_res)
    );

    // Capture the result; drop valid once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {2'b00,
                           btn_res.sleep_request,
                           btn_res.short_press,
                           stim_res.burst_start,
                           btn_res.strength,
                           stim_res.pwm_duty,
                           stim_res.drive_reverse,
                           stim_res.drive_forward};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- src/bbs_regs.sv -----
// APB configuration registers of the stimulator.
// Depends on bbs_pkg for the register map, reset values and t_cfg.
module bbs_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bbs_pkg::t_cfg      o_cfg
);
    import bbs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks      <= PHASE_TICKS_RST;
            r_cfg.pulses_per_burst <= PULSES_RST;
            r_cfg.rest_ticks       <= REST_TICKS_RST;
            r_cfg.debounce_ticks   <= DEBOUNCE_RST;
            r_cfg.long_press_ticks <= LONG_PRESS_RST;
            r_cfg.duty_step        <= DUTY_STEP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PHASE_TICKS: r_cfg.phase_ticks      <= pwdata[7:0];
                REG_PULSES:      r_cfg.pulses_per_burst <= pwdata[7:0];
                REG_REST_TICKS:  r_cfg.rest_ticks       <= pwdata[15:0];
                REG_DEBOUNCE:    r_cfg.debounce_ticks   <= pwdata[15:0];
                REG_LONG_PRESS:  r_cfg.long_press_ticks <= pwdata[15:0];
                REG_DUTY_STEP:   r_cfg.duty_step        <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (reg_idx)
            REG_PHASE_TICKS: prdata = {24'd0, r_cfg.phase_ticks};
            REG_PULSES:      prdata = {24'd0, r_cfg.pulses_per_burst};
            REG_REST_TICKS:  prdata = {16'd0, r_cfg.rest_ticks};
            REG_DEBOUNCE:    prdata = {16'd0, r_cfg.debounce_ticks};
            REG_LONG_PRESS:  prdata = {16'd0, r_cfg.long_press_ticks};
            REG_DUTY_STEP:   prdata = {19'd0, r_cfg.duty_step};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bbs_buttons.sv -----
// Button debounce, strength level and power-button hold timing.
// Depends on bbs_pkg; state advances once per tick when i_adv is high.
module bbs_buttons #(
    parameter logic [3:0] MAX_LEVEL = bbs_pkg::MAX_LEVEL
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [2:0]          i_btn,
    input  bbs_pkg::t_cfg       i_cfg,
    output bbs_pkg::t_btn_res   o_res
);
    import bbs_pkg::*;

    logic [2:0]  r_prev, n_prev;
    logic [15:0] r_quiet [3];
    logic [15:0] n_quiet [3];
    logic [3:0]  r_strength, n_strength, s_plus;
    logic        r_hold_active, n_hold_active;
    logic [15:0] r_hold_timer, n_hold_timer, hold_inc;
    logic [2:0]  edge_ok;
    logic        short_p, sleep_r;

    // Debounce each falling edge against its quiet timer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_prev[i] && !i_btn[i]) begin
                edge_ok[i] = (r_quiet[i] > i_cfg.debounce_ticks);
                n_quiet[i] = 16'd0;
            end else begin
                edge_ok[i] = 1'b0;
                n_quiet[i] = (r_quiet[i] != T16_MAX) ? r_quiet[i] + 16'd1 : r_quiet[i];
            end
        end
        n_prev = i_btn;
    end

    // Apply plus first, then minus, clamped to 0..MAX_LEVEL
    always_comb begin
        s_plus     = (edge_ok[KEY_UP] && (r_strength < MAX_LEVEL))
                     ? r_strength + 4'd1 : r_strength;
        n_strength = (edge_ok[KEY_DOWN] && (s_plus != 4'd0)) ? s_plus - 4'd1 : s_plus;
    end

    // Time the power-button hold; an accepted edge restarts it
    always_comb begin
        hold_inc      = (r_hold_timer != T16_MAX) ? r_hold_timer + 16'd1 : r_hold_timer;
        n_hold_active = r_hold_active;
        n_hold_timer  = r_hold_timer;
        short_p       = 1'b0;
        sleep_r       = 1'b0;
        if (r_hold_active) begin
            if (i_btn[KEY_POWER]) begin
                short_p       = (r_hold_timer < i_cfg.long_press_ticks);
                n_hold_active = 1'b0;
            end else begin
                n_hold_timer = hold_inc;
                if (hold_inc >= i_cfg.long_press_ticks) begin
                    sleep_r       = 1'b1;
                    n_hold_active = 1'b0;
                end
            end
        end
        if (edge_ok[KEY_POWER]) begin
            n_hold_active = 1'b1;
            n_hold_timer  = 16'd0;
        end
    end

    // Advance state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= 3'b111;
            r_quiet[0]    <= 16'd0;
            r_quiet[1]    <= 16'd0;
            r_quiet[2]    <= 16'd0;
            r_strength    <= 4'd0;
            r_hold_active <= 1'b0;
            r_hold_timer  <= 16'd0;
        end else if (i_adv) begin
            r_prev        <= n_prev;
            r_quiet[0]    <= n_quiet[0];
            r_quiet[1]    <= n_quiet[1];
            r_quiet[2]    <= n_quiet[2];
            r_strength    <= n_strength;
            r_hold_active <= n_hold_active;
            r_hold_timer  <= n_hold_timer;
        end
    end

    assign o_res.strength      = n_strength;
    assign o_res.short_press   = short_p;
    assign o_res.sleep_request = sleep_r;

endmodule

// ----- src/bbs_stim.sv -----
// Pulse sequencer: forward, reverse, off; bursts end in rest if set.
// Depends on bbs_pkg; state advances once per tick when i_adv is high.
module bbs_stim (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [3:0]          i_strength,
    input  bbs_pkg::t_cfg       i_cfg,
    output bbs_pkg::t_stim_res  o_res
);
    import bbs_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer, timer_inc, limit;
    logic [7:0]  r_pulse, n_pulse, pulse_inc;
    logic [12:0] r_duty, n_duty;
    logic [16:0] duty_prod;
    logic        first_tick;

    assign first_tick = (r_phase == PH_FWD) && (r_timer == 16'd0);
    assign duty_prod  = {13'd0, i_strength} * {4'd0, i_cfg.duty_step};

    // Latch the saturated duty at the start of each pulse
    always_comb begin
        n_duty = r_duty;
        if (first_tick) begin
            n_duty = (duty_prod > {4'd0, DUTY_MAX}) ? DUTY_MAX : duty_prod[12:0];
        end
    end

    // Drive outputs for the current phase
    always_comb begin
        o_res.drive_forward = (r_phase == PH_FWD);
        o_res.drive_reverse = (r_phase == PH_REV);
        o_res.pwm_duty      = (r_phase == PH_FWD || r_phase == PH_REV) ? n_duty : 13'd0;
        o_res.burst_start   = first_tick && (r_pulse == 8'd0);
    end

    // Step the phase timer and move to the next phase at its limit
    always_comb begin
        timer_inc = (r_timer != T16_MAX) ? r_timer + 16'd1 : r_timer;
        limit     = (r_phase == PH_REST) ? i_cfg.rest_ticks : {8'd0, i_cfg.phase_ticks};
        pulse_inc = r_pulse + 8'd1;
        n_phase   = r_phase;
        n_timer   = timer_inc;
        n_pulse   = r_pulse;
        if (timer_inc >= limit) begin
            n_timer = 16'd0;
            case (r_phase)
                PH_FWD: n_phase = PH_REV;
                PH_REV: n_phase = PH_OFF;
                PH_OFF: begin
                    if (pulse_inc >= i_cfg.pulses_per_burst) begin
                        n_pulse = 8'd0;
                        n_phase = (i_cfg.rest_ticks == 16'd0) ? PH_FWD : PH_REST;
                    end else begin
                        n_pulse = pulse_inc;
                        n_phase = PH_FWD;
                    end
                end
                default: n_phase = PH_FWD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FWD;
            r_timer <= 16'd0;
            r_pulse <= 8'd0;
            r_duty  <= 13'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_pulse <= n_pulse;
            r_duty  <= n_duty;
        end
    end

endmodule

// ----- test/biphasic_burst_stimulator_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the biphasic burst stimulator: it watches the tick, result and APB channels,
// predicts each result from its own copy of the block state and compares it field by field.
// Depends on bbs_pkg.
module biphasic_burst_stimulator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] plus_button, [1] minus_button, [2] power_button
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [0] drive_forward, [1] drive_reverse, [14:2] pwm_duty,
                                     // [18:15] strength_level, [19] burst_start,
                                     // [20] short_press, [21] sleep_request
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_ticks_checked,
    output int          o_bursts,
    output int          o_short_presses,
    output int          o_sleep_requests
);
    import bbs_pkg::*;

    // One result transaction, laid out as in tdata
    typedef struct packed {
        logic        sleep_request;
        logic        short_press;
        logic        burst_start;
        logic [3:0]  strength_level;
        logic [12:0] pwm_duty;
        logic        drive_reverse;
        logic        drive_forward;
    } t_tick_out;

    // Predicted block state
    t_cfg        cfg;
    t_phase      phase;
    logic [15:0] phase_timer;
    logic [7:0]  pulse_count;
    logic [12:0] latched_duty;
    logic [3:0]  strength;
    logic [2:0]  prev_btn;
    logic [15:0] quiet [3];
    logic        hold_active;
    logic [15:0] hold_timer;

    t_tick_out   tick_results_q [$];
    int          fail_count = 0;
    int          ticks_checked = 0;
    int          bursts = 0;
    int          short_presses = 0;
    int          sleep_requests = 0;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_ticks_checked  = 0;
        o_bursts         = 0;
        o_short_presses  = 0;
        o_sleep_requests = 0;
    end

    // Debounce one button; true on an accepted falling edge
    function automatic logic edge_accepted(input int idx, input logic level);
        logic accepted;
        accepted = 1'b0;
        if (prev_btn[idx] && !level) begin
            accepted = quiet[idx] > cfg.debounce_ticks;
            quiet[idx] = '0;
        end else if (quiet[idx] != T16_MAX) begin
            quiet[idx] = quiet[idx] + 16'd1;
        end
        return accepted;
    endfunction

    // Advance the predicted state by one tick and return its result
    task automatic predict_tick(input logic [2:0] btn, output t_tick_out res);
        logic        up;
        logic        down;
        logic        pwr_edge;
        logic [16:0] product;
        logic [15:0] limit;
        res      = '0;
        up       = edge_accepted(KEY_UP, btn[KEY_UP]);
        down     = edge_accepted(KEY_DOWN, btn[KEY_DOWN]);
        pwr_edge = edge_accepted(KEY_POWER, btn[KEY_POWER]);
        prev_btn = btn;

        // Plus goes first, then minus
        if (up && strength < MAX_LEVEL) strength = strength + 4'd1;
        if (down && strength != 4'd0) strength = strength - 4'd1;

        // Power hold: release ends it as a short press, a long hold as sleep
        if (hold_active) begin
            if (btn[KEY_POWER]) begin
                res.short_press = hold_timer < cfg.long_press_ticks;
                hold_active = 1'b0;
            end else begin
                if (hold_timer != T16_MAX) hold_timer = hold_timer + 16'd1;
                if (hold_timer >= cfg.long_press_ticks) begin
                    res.sleep_request = 1'b1;
                    hold_active = 1'b0;
                end
            end
        end
        if (pwr_edge) begin
            hold_active = 1'b1;
            hold_timer  = '0;
        end

        // Latch the duty at the first tick of each pulse
        if (phase == PH_FWD && phase_timer == 16'd0) begin
            product = strength * cfg.duty_step;
            latched_duty = (product > DUTY_MAX) ? DUTY_MAX : product[12:0];
            if (pulse_count == 8'd0) res.burst_start = 1'b1;
        end
        if (phase == PH_FWD) begin
            res.drive_forward = 1'b1;
            res.pwm_duty = latched_duty;
        end else if (phase == PH_REV) begin
            res.drive_reverse = 1'b1;
            res.pwm_duty = latched_duty;
        end
        res.strength_level = strength;

        // Advance the phase sequencer
        if (phase_timer != T16_MAX) phase_timer = phase_timer + 16'd1;
        limit = (phase == PH_REST) ? cfg.rest_ticks : {8'd0, cfg.phase_ticks};
        if (phase_timer >= limit) begin
            phase_timer = '0;
            case (phase)
                PH_FWD: phase = PH_REV;
                PH_REV: phase = PH_OFF;
                PH_OFF: begin
                    pulse_count = pulse_count + 8'd1;
                    if (pulse_count >= cfg.pulses_per_burst) begin
                        pulse_count = '0;
                        phase = (cfg.rest_ticks == 16'd0) ? PH_FWD : PH_REST;
                    end else begin
                        phase = PH_FWD;
                    end
                end
                default: phase = PH_FWD;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Track registers, check results, queue predictions
    always @(posedge i_clk) begin
        t_tick_out predicted;
        t_tick_out seen;
        if (!i_rst_n) begin
            cfg.phase_ticks      = PHASE_TICKS_RST;
            cfg.pulses_per_burst = PULSES_RST;
            cfg.rest_ticks       = REST_TICKS_RST;
            cfg.debounce_ticks   = DEBOUNCE_RST;
            cfg.long_press_ticks = LONG_PRESS_RST;
            cfg.duty_step        = DUTY_STEP_RST;
            phase        = PH_FWD;
            phase_timer  = '0;
            pulse_count  = '0;
            latched_duty = '0;
            strength     = '0;
            prev_btn     = 3'b111;
            quiet[0]     = '0;
            quiet[1]     = '0;
            quiet[2]     = '0;
            hold_active  = 1'b0;
            hold_timer   = '0;
            tick_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_PHASE_TICKS: cfg.phase_ticks      = i_pwdata[7:0];
                    REG_PULSES:      cfg.pulses_per_burst = i_pwdata[7:0];
                    REG_REST_TICKS:  cfg.rest_ticks       = i_pwdata[15:0];
                    REG_DEBOUNCE:    cfg.debounce_ticks   = i_pwdata[15:0];
                    REG_LONG_PRESS:  cfg.long_press_ticks = i_pwdata[15:0];
                    REG_DUTY_STEP:   cfg.duty_step        = i_pwdata[12:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                seen = t_tick_out'(i_m_tdata[21:0]);
                if (tick_results_q.size() == 0) begin
                    $error("result transaction with no tick outstanding: %h", i_m_tdata);
                    fail_count++;
                end else begin
                    predicted = tick_results_q.pop_front();
                    check_field("drive_forward", predicted.drive_forward, seen.drive_forward);
                    check_field("drive_reverse", predicted.drive_reverse, seen.drive_reverse);
                    check_field("pwm_duty", predicted.pwm_duty, seen.pwm_duty);
                    check_field("strength_level", predicted.strength_level,
                                seen.strength_level);
                    check_field("burst_start", predicted.burst_start, seen.burst_start);
                    check_field("short_press", predicted.short_press, seen.short_press);
                    check_field("sleep_request", predicted.sleep_request,
                                seen.sleep_request);
                    ticks_checked++;
                    bursts         += predicted.burst_start;
                    short_presses  += predicted.short_press;
                    sleep_requests += predicted.sleep_request;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tdata[2:0], predicted);
                tick_results_q.push_back(predicted);
            end
        end
        o_fail_count     <= fail_count;
        o_pending        <= tick_results_q.size();
        o_ticks_checked  <= ticks_checked;
        o_bursts         <= bursts;
        o_short_presses  <= short_presses;
        o_sleep_requests <= sleep_requests;
    end

endmodule

// ----- test/biphasic_burst_stimulator_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the biphasic burst stimulator: clock, reset, button tick stimulus,
// APB register setups, result-side stalls and the verdict.
// Depends on bbs_pkg, biphasic_burst_stimulator_top and biphasic_burst_stimulator_checker.
module biphasic_burst_stimulator_top_test;
    import bbs_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ROUNDS = 13;
    localparam int ROUND_TICKS   = 110;
    localparam int DRAIN_CYCLES  = 4;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW
    } t_rx_mode;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'hFF;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int ticks_checked;
    int bursts;
    int short_presses;
    int sleep_requests;

    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       cur_debounce = 500;
    int       cur_long     = 1000;
    int       setups_done  = 1;
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;

    biphasic_burst_stimulator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    biphasic_burst_stimulator_checker scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_ticks_checked  (ticks_checked),
        .o_bursts         (bursts),
        .o_short_presses  (short_presses),
        .o_sleep_requests (sleep_requests)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Result side: switch between open, coin-flip and mostly-stalled stretches
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(16, 160);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Send one tick transaction; idle between bursts of random length
    task automatic send_tick(input logic [2:0] btn);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, btn};
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input int ph, input int pulses, input int rest,
                             input int deb, input int long_press, input int duty);
        apb_write(REG_PHASE_TICKS, ph);
        apb_write(REG_PULSES, pulses);
        apb_write(REG_REST_TICKS, rest);
        apb_write(REG_DEBOUNCE, deb);
        apb_write(REG_LONG_PRESS, long_press);
        apb_write(REG_DUTY_STEP, duty);
        cur_debounce = deb;
        cur_long     = long_press;
        setups_done++;
    endtask

    // Pick a register setup: mostly short timings, now and then an extreme
    task automatic program_round(input logic all_max);
        int ph, pulses, rest, deb, long_press, duty, r;
        if (all_max) begin
            write_all(255, 255, 65535, 65535, 65535, 8191);
        end else begin
            r = $urandom_range(0, 9);
            ph = (r == 0) ? 255 : (r == 1) ? 0 : $urandom_range(1, 4);
            r = $urandom_range(0, 9);
            pulses = (r == 0) ? 255 : (r == 1) ? 0 : $urandom_range(1, 3);
            r = $urandom_range(0, 9);
            rest = (r == 0) ? 65535 : (r < 3) ? 0 : $urandom_range(1, 6);
            r = $urandom_range(0, 11);
            deb = (r == 0) ? 65535 : (r == 1) ? 500 : $urandom_range(0, 5);
            r = $urandom_range(0, 11);
            long_press = (r == 0) ? 65535 : (r == 1) ? 0 : $urandom_range(1, 12);
            r = $urandom_range(0, 7);
            duty = (r == 0) ? 8191 : (r == 1) ? 0 : $urandom_range(0, 8191);
            write_all(ph, pulses, rest, deb, long_press, duty);
        end
    endtask

    // Button gestures (press, hold, release) with noise in between
    task automatic run_random(input int ticks);
        int         sent;
        int         hold_len;
        int         gap_len;
        int         j;
        logic [2:0] pressed;
        sent = 0;
        while (sent < ticks) begin
            if ($urandom_range(0, 3) != 0) begin
                pressed  = 3'($urandom_range(1, 7));
                hold_len = $urandom_range(1, (cur_long > 30) ? 30 : cur_long + 3);
                gap_len  = $urandom_range(0, (cur_debounce > 30) ? 30 : cur_debounce + 3);
                for (j = 0; j < hold_len && sent < ticks; j++) begin
                    send_tick(~pressed);
                    sent++;
                end
                for (j = 0; j < gap_len && sent < ticks; j++) begin
                    send_tick(3'b111);
                    sent++;
                end
            end else begin
                hold_len = $urandom_range(1, 8);
                for (j = 0; j < hold_len && sent < ticks; j++) begin
                    send_tick(3'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("biphasic_burst_stimulator_top_test NOT OK");
        $finish;
    end

    initial begin
        int round;
        int k;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: early edges fall inside the debounce window
        send_tick(3'b000);
        send_tick(3'b111);
        drain_idle();

        // Shortest timings, zero debounce and long press, full duty step
        write_all(0, 0, 0, 0, 0, 8191);
        send_tick(3'b101);    // minus at level zero
        send_tick(3'b000);    // all low: plus steps up, minus is still held, power hold starts
        send_tick(3'b000);    // hold reaches a zero long press
        send_tick(3'b111);
        for (k = 0; k < 10; k++) begin
            // climb past the top level, duty saturates
            send_tick(3'b110);
            send_tick(3'b111);
        end

        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            drain_idle();
            program_round(round == 0);
            run_random(ROUND_TICKS);
        end

        drain_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d ticks over %0d register setups with random gaps and stalls.",
                 ticks_checked, setups_done);
        $display("Seen %0d burst starts, %0d short presses, %0d sleep requests.",
                 bursts, short_presses, sleep_requests);
        if (fail_count == 0 && pending == 0) begin
            $display("biphasic_burst_stimulator_top_test OK");
        end else begin
            $display("biphasic_burst_stimulator_top_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bbs_pkg.sv
src/bbs_regs.sv
src/bbs_buttons.sv
src/bbs_stim.sv
src/biphasic_burst_stimulator_top.sv
test/biphasic_burst_stimulator_checker.sv
test/biphasic_burst_stimulator_top_test.sv
